[rtl/spq_pkg.sv]
// Package for the stable priority queue: shared widths, codes, state and
// command types. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 16;

   localparam int VALUE_W     = 32;
   localparam int IN_PRIO_W   = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_DROP_FULL = 2'd1,
      STAT_DEQ_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_HOLD = 1'b1
   } state_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
// Controller for the stable priority queue: handshake state machine that
// issues execute commands to the datapath. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output spq_pkg::cmd_type     cmd
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            rsp_valid = 1'b0;
         end
         spq_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
      // A new transfer may enter whenever the result register is free or
      // is being emptied in this same cycle.
      req_stall = rsp_valid && rsp_stall;
      cmd.exec  = req_valid && !req_stall;
      if (cmd.exec) begin
         state_in = spq_pkg::ST_HOLD;
      end else if (!rsp_stall) begin
         state_in = spq_pkg::ST_IDLE;
      end
   end

endmodule
`default_nettype wire

[rtl/spq_datapath.sv]
// Datapath for the stable priority queue: sorted register cells with
// parallel compare-and-shift, fill count and result registers. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire spq_pkg::cmd_type                       cmd,
   input  wire logic                                   req_operation,
   input  wire logic        [spq_pkg::VALUE_W-1:0]     req_item_value,
   input  wire logic signed [spq_pkg::IN_PRIO_W-1:0]   req_item_priority,
   output logic             [spq_pkg::VALUE_W-1:0]     rsp_head_value,
   output logic signed      [spq_pkg::IN_PRIO_W-1:0]   rsp_head_priority,
   output logic             [spq_pkg::STATUS_W-1:0]    rsp_status,
   output logic             [spq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                                        rsp_queue_empty
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic        [spq_pkg::VALUE_W-1:0] val_ff [CAPACITY];
   logic        [spq_pkg::VALUE_W-1:0] val_in [CAPACITY];
   logic signed [PRIORITY_BITS-1:0]    pri_ff [CAPACITY];
   logic signed [PRIORITY_BITS-1:0]    pri_in [CAPACITY];
   logic        [CNT_W-1:0]            count_ff;
   logic        [CNT_W-1:0]            count_in;

   logic signed [PRIORITY_BITS-1:0]    new_pri;
   logic        [CAPACITY-1:0]         gt;
   logic        [CAPACITY-1:0]         shift_en;
   logic                               is_full;
   logic                               is_empty;

   logic        [spq_pkg::VALUE_W-1:0]     head_value_ff, head_value_in;
   logic signed [spq_pkg::IN_PRIO_W-1:0]   head_pri_ff, head_pri_in;
   spq_pkg::status_type                    status_ff, status_in;
   logic        [spq_pkg::COUNT_OUT_W-1:0] count_out_ff, count_out_in;
   logic                                   empty_ff, empty_in;

   // The low PRIORITY_BITS bits of the field form the stored priority.
   assign new_pri  = PRIORITY_BITS'($unsigned(req_item_priority));
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // A cell moves back when it holds a strictly larger priority number.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (pri_ff[i] > new_pri);
      end
      shift_en[0] = 1'b0;
      for (int i = 1; i < CAPACITY; i++) begin
         shift_en[i] = gt[i-1];
      end
   end

   always_comb begin
      val_in        = val_ff;
      pri_in        = pri_ff;
      count_in      = count_ff;
      head_value_in = '0;
      head_pri_in   = '0;
      status_in     = spq_pkg::STAT_DONE;
      if (req_operation == spq_pkg::OP_ENQUEUE) begin
         if (is_full) begin
            status_in = spq_pkg::STAT_DROP_FULL;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (!shift_en[i] && (gt[i] || (CNT_W'(i) == count_ff))) begin
                  val_in[i] = req_item_value;
                  pri_in[i] = new_pri;
               end
            end
            for (int i = 1; i < CAPACITY; i++) begin
               if (shift_en[i]) begin
                  val_in[i] = val_ff[i-1];
                  pri_in[i] = pri_ff[i-1];
               end
            end
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (is_empty) begin
            status_in = spq_pkg::STAT_DEQ_EMPTY;
         end else begin
            head_value_in = val_ff[0];
            head_pri_in   = spq_pkg::IN_PRIO_W'(pri_ff[0]);
            for (int i = 0; i < CAPACITY - 1; i++) begin
               val_in[i] = val_ff[i+1];
               pri_in[i] = pri_ff[i+1];
            end
            count_in = count_ff - 1'b1;
         end
      end
      count_out_in = spq_pkg::COUNT_OUT_W'(count_in);
      empty_in     = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         val_ff        <= val_in;
         pri_ff        <= pri_in;
         head_value_ff <= head_value_in;
         head_pri_ff   <= head_pri_in;
         status_ff     <= status_in;
         count_out_ff  <= count_out_in;
         empty_ff      <= empty_in;
      end
   end

   assign rsp_head_value    = head_value_ff;
   assign rsp_head_priority = head_pri_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_out_ff;
   assign rsp_queue_empty   = empty_ff;

endmodule
`default_nettype wire

[rtl/stable_priority_queue.sv]
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one request per cycle while the result side does not stall.
// Each operation is one parallel compare-and-shift over the register cells.
// Reset clears the fill count and the result valid flag; cell contents are
// left as they are and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_operation,
   input  wire logic        [spq_pkg::VALUE_W-1:0]     req_item_value,
   input  wire logic signed [spq_pkg::IN_PRIO_W-1:0]   req_item_priority,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic             [spq_pkg::VALUE_W-1:0]     rsp_head_value,
   output logic signed      [spq_pkg::IN_PRIO_W-1:0]   rsp_head_priority,
   output logic             [spq_pkg::STATUS_W-1:0]    rsp_status,
   output logic             [spq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                                        rsp_queue_empty
);

   // The controller owns the handshake and tells the datapath when a
   // transfer is taken. The datapath then updates the sorted cells and
   // loads the result register in that same clock edge.
   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Entries are kept in ascending priority order with the head in cell
   // zero. An enqueue lands after every entry of equal or smaller
   // priority, so equal priorities leave in arrival order.
   spq_datapath #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_queue_empty   (rsp_queue_empty)
   );

endmodule
`default_nettype wire

[rtl/spq_checker.sv]
// Port-level checker for the stable priority queue and its bind to the
// top level. Depends on spq_pkg and stable_priority_queue.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_stall,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic        [spq_pkg::VALUE_W-1:0]     rsp_head_value,
   input wire logic signed [spq_pkg::IN_PRIO_W-1:0]   rsp_head_priority,
   input wire logic        [spq_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic        [spq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   input wire logic                                   rsp_queue_empty
);

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("no result after a request transfer");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != spq_pkg::STAT_DONE) |->
         (rsp_head_value == '0) && (rsp_head_priority == '0))
      else $error("failed operation returned a head entry");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> (rsp_entry_count == '0))
      else $error("empty flag with nonzero count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == spq_pkg::STAT_DONE) ||
         (rsp_status == spq_pkg::STAT_DROP_FULL) ||
         (rsp_status == spq_pkg::STAT_DEQ_EMPTY))
      else $error("undefined status code");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_head_value    (rsp_head_value),
   .rsp_head_priority (rsp_head_priority),
   .rsp_status        (rsp_status),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_queue_empty   (rsp_queue_empty)
);
`default_nettype wire
